// ===== design/box_vs_building_table_collision_top_assert.svh =====
// Assertion macros shared by the collision search RTL.
// Clock and active-low reset are passed in by the caller.
`ifndef BOX_VS_BUILDING_TABLE_COLLISION_TOP_ASSERT_SVH
`define BOX_VS_BUILDING_TABLE_COLLISION_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define BVB_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant check failed");

`define BVB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

`define BVB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`else

`define BVB_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define BVB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BVB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/bvb_pkg.sv =====
// Shared types and constants for the box versus building table search.
// No dependencies.
`timescale 1ns / 1ps

package bvb_pkg;

	localparam int ENTRIES    = 256;
	localparam int TILE_UNITS = 128;

	// cell index width: wide enough for the table and for the 9-bit skip index
	localparam int CIDX_W = ($clog2(ENTRIES) > 9) ? $clog2(ENTRIES) : 9;

	// world coordinate width: (tile - w/2) is 13 bits signed, scaled by TILE_UNITS,
	// plus room for the upper corner; never narrower than a sign-extended query
	localparam int CW_RAW = 13 + $clog2(TILE_UNITS) + 2;
	localparam int CW     = (CW_RAW > 22) ? CW_RAW : 22;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef logic signed [CW-1:0] coord_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// entry load broadcast to all cells
	typedef struct packed {
		logic [CIDX_W-1:0] idx;
		logic              on;
		coord_t            lx;
		coord_t            ly;
		coord_t            ux;
		coord_t            uy;
	} wr_t;

	// query broadcast to all cells
	typedef struct packed {
		coord_t            min_x;
		coord_t            min_y;
		coord_t            max_x;
		coord_t            max_y;
		logic              skip_en;
		logic [CIDX_W-1:0] skip_idx;
	} qry_t;

	// scan token handed from cell to cell
	typedef struct packed {
		logic       act;
		logic       found;
		logic [7:0] idx;
	} tok_t;

endpackage

// ===== design/box_vs_building_table_collision_top.sv =====
// Box versus building footprint table with first-match overlap search.
// A write transfer goes straight to the done state; a query launches a token
// walking the cell row one slot a cycle, and its result is loaded when the token
// leaves the row. Input stalls outside idle, so one transfer is handled at a time.
// Reset (arst_n, async) clears all valid marks and control state; no clearing pass.
`timescale 1ns / 1ps
`include "box_vs_building_table_collision_top_assert.svh"

module box_vs_building_table_collision_top import bvb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [7:0]         entry_index,
	input  logic               entry_on,
	input  logic [11:0]        tile_x,
	input  logic [11:0]        tile_y,
	input  logic [5:0]         width_x,
	input  logic [5:0]         width_y,
	input  logic signed [20:0] box_min_x,
	input  logic signed [20:0] box_min_y,
	input  logic signed [20:0] box_max_x,
	input  logic signed [20:0] box_max_y,
	input  logic signed [8:0]  ignore_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic [7:0]         collider_index
);

	localparam coord_t TILE_C = coord_t'(TILE_UNITS);

	state_t state_q, state_d;

	logic in_xfer, wr_xfer, qry_xfer;
	logic out_free;
	logic done_load;

	logic       wr_en_s1;
	wr_t        wr_s1;
	qry_t       qry_q;
	logic       launch_q;
	logic       pend_hit_q;
	logic [7:0] pend_idx_q;
	logic       out_valid_q;
	logic       hit_q;
	logic [7:0] collider_index_q;

	logic signed [12:0] base_x, base_y;
	coord_t base_x_ext, base_y_ext;
	coord_t lx, ly, span_x, span_y;

	tok_t             chain [ENTRIES+1];
	logic [ENTRIES-1:0] act_vec;
	tok_t             tail;

	assign in_xfer  = in_valid && !in_stall;
	assign wr_xfer  = in_xfer && (mode == MODE_WRITE);
	assign qry_xfer = in_xfer && (mode == MODE_QUERY);
	assign out_free = !out_valid_q || !out_stall;
	assign tail     = chain[ENTRIES];

	// entry corners folded in at load time
	assign base_x = $signed({1'b0, tile_x}) - $signed({8'd0, width_x[5:1]});
	assign base_y = $signed({1'b0, tile_y}) - $signed({8'd0, width_y[5:1]});
	assign base_x_ext = CW'(base_x);
	assign base_y_ext = CW'(base_y);
	assign lx = base_x_ext * TILE_C;
	assign ly = base_y_ext * TILE_C;
	assign span_x = coord_t'({{(CW-6){1'b0}}, width_x}) * TILE_C;
	assign span_y = coord_t'({{(CW-6){1'b0}}, width_y}) * TILE_C;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		done_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = (mode == MODE_QUERY) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (tail.act) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					done_load = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1    <= 1'b0;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_en_s1 <= wr_xfer;
			launch_q <= qry_xfer;
			if (done_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_xfer) begin
			wr_s1.idx <= CIDX_W'(entry_index);
			wr_s1.on  <= entry_on;
			wr_s1.lx  <= lx;
			wr_s1.ly  <= ly;
			wr_s1.ux  <= lx + span_x - coord_t'(1);
			wr_s1.uy  <= ly + span_y - coord_t'(1);
		end
		if (qry_xfer) begin
			qry_q.min_x    <= coord_t'(box_min_x);
			qry_q.min_y    <= coord_t'(box_min_y);
			qry_q.max_x    <= coord_t'(box_max_x);
			qry_q.max_y    <= coord_t'(box_max_y);
			qry_q.skip_en  <= !ignore_index[8];
			qry_q.skip_idx <= CIDX_W'(ignore_index[7:0]);
		end
		if (wr_xfer) begin
			pend_hit_q <= 1'b0;
			pend_idx_q <= 8'd0;
		end else if ((state_q == ST_SCAN) && tail.act) begin
			pend_hit_q <= tail.found;
			pend_idx_q <= tail.idx;
		end
		if (done_load) begin
			hit_q            <= pend_hit_q;
			collider_index_q <= pend_idx_q;
		end
	end

	assign chain[0].act   = launch_q;
	assign chain[0].found = 1'b0;
	assign chain[0].idx   = 8'd0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		bvb_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_index (CIDX_W'(i)),
			.wr_en      (wr_en_s1),
			.wr         (wr_s1),
			.qry        (qry_q),
			.tok_in     (chain[i]),
			.tok_out    (chain[i+1])
		);
		assign act_vec[i] = chain[i+1].act;
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign collider_index = collider_index_q;

	`BVB_ASSERT_ALWAYS(a_single_token, clk, arst_n, $onehot0(act_vec))
	`BVB_ASSERT_IMP(a_launch_row_empty, clk, arst_n, launch_q, act_vec == '0)
	`BVB_ASSERT_IMP(a_token_only_in_scan, clk, arst_n, act_vec != '0, state_q == ST_SCAN)
	`BVB_ASSERT_IMP(a_out_from_done, clk, arst_n, $rose(out_valid_q),
		$past(state_q == ST_DONE))
	`BVB_ASSERT_IMP(a_miss_index_zero, clk, arst_n, out_valid_q && !hit_q,
		collider_index_q == 8'd0)

endmodule

// ===== design/bvb_cell.sv =====
// One table slot: holds an entry's world-unit box and checks the passing query.
// Depends on bvb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "box_vs_building_table_collision_top_assert.svh"

module bvb_cell import bvb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CIDX_W-1:0] cell_index,
	input  logic              wr_en,
	input  wr_t               wr,
	input  qry_t              qry,
	input  tok_t              tok_in,
	output tok_t              tok_out
);

	logic   valid_q;
	coord_t lx_q, ly_q, ux_q, uy_q;
	logic   act_q, found_q;
	logic [7:0] idx_q;

	logic wr_sel;
	logic overlap;
	logic match;

	assign wr_sel = wr_en && (wr.idx == cell_index);

	assign overlap = (qry.max_x >= lx_q) && (qry.max_y >= ly_q) &&
		(qry.min_x <= ux_q) && (qry.min_y <= uy_q);

	assign match = valid_q && overlap && !(qry.skip_en && (qry.skip_idx == cell_index));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			act_q   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (wr_sel) begin
				valid_q <= wr.on;
			end
			act_q   <= tok_in.act;
			found_q <= tok_in.act && (tok_in.found || match);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_sel) begin
			lx_q <= wr.lx;
			ly_q <= wr.ly;
			ux_q <= wr.ux;
			uy_q <= wr.uy;
		end
		// earlier hit wins; otherwise take this slot on a match
		if (tok_in.found || !match) begin
			idx_q <= tok_in.idx;
		end else begin
			idx_q <= cell_index[7:0];
		end
	end

	assign tok_out.act   = act_q;
	assign tok_out.found = found_q;
	assign tok_out.idx   = idx_q;

	`BVB_ASSERT_IMP(a_found_with_token, clk, arst_n, found_q, act_q)
	`BVB_ASSERT_NEXT(a_hit_sticks, clk, arst_n, tok_in.act && tok_in.found, found_q)
	`BVB_ASSERT_NEXT(a_first_hit_kept, clk, arst_n, tok_in.act && tok_in.found,
		idx_q == $past(tok_in.idx))

endmodule
